/* src/saq_pkg.sv */
// Package for the sorted alarm queue: sizes, codes, cell and control types.
// No dependencies.
package saq_pkg;

   localparam int MaxAlarms = 16;
   localparam int HandleCapacity = 255;
   localparam int RecWidth = $clog2(MaxAlarms);
   localparam int HandleWidth = 8;

   typedef logic [RecWidth-1:0] rec_type;
   typedef logic [HandleWidth-1:0] handle_type;

   typedef enum logic [1:0] {
      MODE_DELETE = 2'd0,
      MODE_SET    = 2'd1,
      MODE_CYCLE  = 2'd2,
      MODE_KILL   = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      ST_OK         = 2'd0,
      ST_BAD_HANDLE = 2'd1,
      ST_NO_ROOM    = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_WORK,
      S_DONE
   } state_type;

   // contents of one queue cell
   typedef struct packed {
      logic        valid;
      logic [15:0] owner;
      logic [31:0] due;
      rec_type     rec;
   } cell_type;

   // command broadcast from control to every cell
   typedef struct packed {
      logic        insert;
      logic        remove_rec;
      logic        remove_owner;
      logic [15:0] owner;
      logic [31:0] due;
      rec_type     rec;
   } cmd_type;

endpackage

/* src/saq_cell.sv */
// One queue cell: holds one alarm entry, takes from left or right neighbor.
// Depends on saq_pkg.
module saq_cell (
   input  logic              clock,
   input  logic              reset,
   input  saq_pkg::cmd_type  cmd,
   input  saq_pkg::cell_type left_cell,
   input  logic              left_ins,
   input  logic              left_del,
   input  saq_pkg::cell_type right_cell,
   output saq_pkg::cell_type cell_out,
   output logic              ins_out,
   output logic              del_out
);
   saq_pkg::cell_type cell_ff, cell_in;
   logic here_del, here_ins;

   always_comb begin
      here_ins = cell_ff.valid && (cell_ff.due > cmd.due);
      here_ins = here_ins || !cell_ff.valid;
      ins_out = left_ins || here_ins;
      // only the first matching cell removes itself in a cycle
      here_del = !left_del && cell_ff.valid &&
                 ((cmd.remove_rec && cell_ff.rec == cmd.rec) ||
                  (cmd.remove_owner && cell_ff.owner == cmd.owner));
      del_out = left_del || here_del;
      cell_in = cell_ff;
      if (cmd.insert) begin
         if (left_ins) begin
            cell_in = left_cell;
         end else if (here_ins) begin
            cell_in.valid = 1'b1;
            cell_in.owner = cmd.owner;
            cell_in.due = cmd.due;
            cell_in.rec = cmd.rec;
         end
      end else if (del_out) begin
         cell_in = right_cell;
      end
   end

   assign cell_out = cell_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff.valid <= 1'b0;
      end else begin
         cell_ff.valid <= cell_in.valid;
      end
      cell_ff.owner <= cell_in.owner;
      cell_ff.due <= cell_in.due;
      cell_ff.rec <= cell_in.rec;
   end
endmodule

/* src/saq_chain.sv */
// Row of queue cells sorted by due tick; presence of each record index.
// Depends on saq_pkg and saq_cell.
module saq_chain (
   input  logic                           clock,
   input  logic                           reset,
   input  saq_pkg::cmd_type               cmd,
   output logic [saq_pkg::MaxAlarms-1:0]  rec_live,
   output logic                           owner_hit
);
   saq_pkg::cell_type cells [saq_pkg::MaxAlarms+1];
   logic ins [saq_pkg::MaxAlarms+1];
   logic del [saq_pkg::MaxAlarms+1];
   saq_pkg::cell_type empty_cell;

   assign empty_cell = '0;
   assign cells[0] = empty_cell;
   assign ins[0] = 1'b0;
   assign del[0] = 1'b0;

   for (genvar i = 0; i < saq_pkg::MaxAlarms; i++) begin : g_cell
      saq_pkg::cell_type right_c;
      if (i == saq_pkg::MaxAlarms - 1) begin : g_last
         assign right_c = empty_cell;
      end else begin : g_mid
         assign right_c = cells[i+2];
      end
      saq_cell u_cell (
         .clock(clock), .reset(reset), .cmd(cmd),
         .left_cell(cells[i]), .left_ins(ins[i]), .left_del(del[i]),
         .right_cell(right_c),
         .cell_out(cells[i+1]), .ins_out(ins[i+1]), .del_out(del[i+1])
      );
   end

   always_comb begin
      rec_live = '0;
      owner_hit = 1'b0;
      for (int i = 1; i <= saq_pkg::MaxAlarms; i++) begin
         if (cells[i].valid) begin
            rec_live[cells[i].rec] = 1'b1;
            if (cells[i].owner == cmd.owner) owner_hit = 1'b1;
         end
      end
   end
endmodule

/* src/sorted_alarm_queue_top.sv */
// Top level of the sorted alarm queue: request decode, handle map, cell chain.
// Depends on saq_pkg and saq_chain.
// Each request passes through S_IDLE, S_WORK and S_DONE; a kill stays in S_WORK
// while an entry of that owner is left in the chain.
// One request at a time: a new request word is taken only after the response word is accepted.
// Queue work: insert or delete is a single chain command; kill removes one entry a cycle.
// Reset clears the queue, handle map valid bits and next handle at once.
module sorted_alarm_queue_top (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // mode[1:0] owner_pid[17:2] caller_handle[25:18] signal_code[41:26]
   // delay_ticks[73:42] now_tick[105:74], zero fill
   input  logic [111:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // status[1:0] handle_out[9:2], zero fill
   output logic [15:0]  rsp_tdata
);
   saq_pkg::state_type state_ff, state_in;
   logic [1:0] mode_ff;
   logic [15:0] owner_ff;
   saq_pkg::handle_type handle_ff, hout_ff, hout_in, next_handle_ff, next_handle_in;
   logic [31:0] due_ff;
   logic [1:0] status_ff, status_in;
   logic [saq_pkg::HandleCapacity-1:0] map_valid_ff, map_valid_in;
   saq_pkg::rec_type map_rec_ff [saq_pkg::HandleCapacity];
   saq_pkg::handle_type rec_handle_ff [saq_pkg::MaxAlarms];
   saq_pkg::rec_type del_rec_ff;
   logic [saq_pkg::MaxAlarms-1:0] rec_live;
   logic owner_hit;
   saq_pkg::cmd_type cmd;
   saq_pkg::rec_type free_rec, del_rec;
   logic free_ok, del_ok, map_write;

   assign req_tready = (state_ff == saq_pkg::S_IDLE);
   assign rsp_tvalid = (state_ff == saq_pkg::S_DONE);
   assign rsp_tdata = {6'd0, hout_ff, status_ff};

   always_comb begin
      free_ok = 1'b0;
      free_rec = '0;
      for (int i = saq_pkg::MaxAlarms - 1; i >= 0; i--) begin
         if (!rec_live[i]) begin
            free_ok = 1'b1;
            free_rec = saq_pkg::RecWidth'(i);
         end
      end
      del_rec = del_rec_ff;
      // a handle is stale once its record was freed or reused
      del_ok = (handle_ff < 8'(saq_pkg::HandleCapacity)) && map_valid_ff[handle_ff] &&
               rec_live[del_rec] && (rec_handle_ff[del_rec] == handle_ff);
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         saq_pkg::S_IDLE: if (req_tvalid) state_in = saq_pkg::S_WORK;
         saq_pkg::S_WORK: begin
            if (!(mode_ff == saq_pkg::MODE_KILL && owner_ff != 16'd0 && owner_hit))
               state_in = saq_pkg::S_DONE;
         end
         saq_pkg::S_DONE: if (rsp_tready) state_in = saq_pkg::S_IDLE;
         default: state_in = saq_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      cmd.owner = owner_ff;
      cmd.due = due_ff;
      status_in = saq_pkg::ST_OK;
      hout_in = '0;
      map_write = 1'b0;
      map_valid_in = map_valid_ff;
      next_handle_in = next_handle_ff;
      if (state_ff == saq_pkg::S_WORK) begin
         case (mode_ff)
            saq_pkg::MODE_DELETE: begin
               if (del_ok) begin
                  cmd.remove_rec = 1'b1;
                  cmd.rec = del_rec;
               end else begin
                  status_in = saq_pkg::ST_BAD_HANDLE;
               end
            end
            saq_pkg::MODE_KILL: cmd.remove_owner = (owner_ff != 16'd0) && owner_hit;
            default: begin
               if (handle_ff != '0 || owner_ff == 16'd0) begin
                  status_in = saq_pkg::ST_BAD_HANDLE;
               end else if (next_handle_ff >= 8'(saq_pkg::HandleCapacity) || !free_ok) begin
                  status_in = saq_pkg::ST_NO_ROOM;
               end else begin
                  cmd.insert = 1'b1;
                  cmd.rec = free_rec;
                  map_write = 1'b1;
                  map_valid_in[next_handle_ff] = 1'b1;
                  hout_in = next_handle_ff;
                  next_handle_in = next_handle_ff + 8'd1;
               end
            end
         endcase
      end
   end

   saq_chain u_chain (
      .clock(clock), .reset(reset), .cmd(cmd),
      .rec_live(rec_live), .owner_hit(owner_hit)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= saq_pkg::S_IDLE;
         map_valid_ff <= '0;
         next_handle_ff <= '0;
      end else begin
         state_ff <= state_in;
         map_valid_ff <= map_valid_in;
         next_handle_ff <= next_handle_in;
      end
      if (map_write) begin
         map_rec_ff[next_handle_ff] <= free_rec;
         rec_handle_ff[free_rec] <= next_handle_ff;
      end
      if (state_ff == saq_pkg::S_IDLE) begin
         mode_ff <= req_tdata[1:0];
         owner_ff <= req_tdata[17:2];
         handle_ff <= req_tdata[25:18];
         due_ff <= req_tdata[73:42] + req_tdata[105:74];
         del_rec_ff <= map_rec_ff[(req_tdata[25:18] < 8'(saq_pkg::HandleCapacity)) ?
                                  req_tdata[25:18] : '0];
      end
      if (state_ff == saq_pkg::S_WORK) begin
         status_ff <= status_in;
         hout_ff <= hout_in;
      end
   end

   // kill leaves no entry of that owner
   a_kill_clean: assert property (@(posedge clock) disable iff (reset)
      (state_ff == saq_pkg::S_DONE && mode_ff == saq_pkg::MODE_KILL && owner_ff != 16'd0)
      |-> !owner_hit)
      else $error("kill left an entry");
   a_handle_mono: assert property (@(posedge clock) disable iff (reset)
      next_handle_ff <= 8'(saq_pkg::HandleCapacity))
      else $error("handle overflow");
   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      cmd.insert |=> $countones(rec_live) == $past($countones(rec_live)) + 1)
      else $error("insert lost");
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("overlap");
endmodule

/* tb/saq_checker.sv */
// Checker for the sorted alarm queue: watches request and response words,
// predicts status and handle per request and compares. Depends on saq_pkg.
`timescale 1ns / 100ps
module saq_checker
   import saq_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [111:0] req_tdata,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [15:0]  rsp_tdata,
   output int           fail_count,
   output int           pending
);

   typedef struct {
      status_type status;
      handle_type handle;
   } answer_type;

   answer_type answers[$];

   logic        q_valid[MaxAlarms];
   int          q_rec[MaxAlarms];
   logic [15:0] owner_of[MaxAlarms];
   logic [31:0] due_of[MaxAlarms];
   logic        map_valid[HandleCapacity];
   int          map_rec[HandleCapacity];
   int          issued;

   assign pending = answers.size();

   function automatic void clear_alarms();
      for (int k = 0; k < MaxAlarms; k++) begin
         q_valid[k] = 0;
         q_rec[k] = 0;
         owner_of[k] = 0;
         due_of[k] = 0;
      end
      for (int k = 0; k < HandleCapacity; k++) begin
         map_valid[k] = 0;
         map_rec[k] = 0;
      end
      issued = 0;
   endfunction

   function automatic void enqueue_by_due(int rec);
      int pos;
      pos = 0;
      while (pos < MaxAlarms && q_valid[pos] && due_of[q_rec[pos]] <= due_of[rec])
         pos++;
      if (pos >= MaxAlarms)
         return;
      for (int k = MaxAlarms - 1; k > pos; k--) begin
         q_valid[k] = q_valid[k-1];
         q_rec[k] = q_rec[k-1];
      end
      q_valid[pos] = 1;
      q_rec[pos] = rec;
   endfunction

   function automatic void free_alarm(int rec);
      bit found;
      found = 0;
      for (int k = 0; k < MaxAlarms; k++) begin
         if (!found && q_valid[k] && q_rec[k] == rec)
            found = 1;
         if (found) begin
            if (k + 1 < MaxAlarms) begin
               q_valid[k] = q_valid[k+1];
               q_rec[k] = q_rec[k+1];
            end else begin
               q_valid[k] = 0;
               q_rec[k] = 0;
            end
         end
      end
      owner_of[rec] = 0;
      for (int k = 0; k < HandleCapacity; k++)
         if (map_valid[k] && map_rec[k] == rec)
            map_valid[k] = 0;
   endfunction

   function automatic answer_type apply_request(logic [111:0] word);
      answer_type a;
      mode_type   mode;
      logic [15:0] owner;
      logic [7:0]  hnd;
      logic [31:0] delay, now;
      int rec, k;
      mode  = mode_type'(word[1:0]);
      owner = word[17:2];
      hnd   = word[25:18];
      delay = word[73:42];
      now   = word[105:74];
      a.status = ST_OK;
      a.handle = '0;
      case (mode)
         MODE_DELETE: begin
            if (hnd < HandleCapacity && map_valid[hnd] && owner_of[map_rec[hnd]] != 0)
               free_alarm(map_rec[hnd]);
            else
               a.status = ST_BAD_HANDLE;
         end
         MODE_KILL: begin
            if (owner != 0) begin
               k = 0;
               while (k < MaxAlarms) begin
                  if (q_valid[k] && owner_of[q_rec[k]] == owner)
                     free_alarm(q_rec[k]);
                  else
                     k++;
               end
            end
         end
         default: begin
            if (hnd != 0 || owner == 0) begin
               a.status = ST_BAD_HANDLE;
            end else if (issued >= HandleCapacity) begin
               a.status = ST_NO_ROOM;
            end else begin
               rec = MaxAlarms;
               for (int j = MaxAlarms - 1; j >= 0; j--)
                  if (owner_of[j] == 0)
                     rec = j;
               if (rec >= MaxAlarms) begin
                  a.status = ST_NO_ROOM;
               end else begin
                  owner_of[rec] = owner;
                  due_of[rec] = delay + now;
                  enqueue_by_due(rec);
                  map_valid[issued] = 1;
                  map_rec[issued] = rec;
                  a.handle = handle_type'(issued);
                  issued++;
               end
            end
         end
      endcase
      return a;
   endfunction

   always @(posedge clock) begin
      answer_type want;
      if (reset) begin
         clear_alarms();
         answers.delete();
         fail_count <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (answers.size() == 0) begin
               $error("unexpected response word %h", rsp_tdata);
               fail_count <= fail_count + 1;
            end else begin
               want = answers.pop_front();
               if (rsp_tdata[1:0] !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_tdata[1:0]);
                  fail_count <= fail_count + 1;
               end else if (rsp_tdata[9:2] !== want.handle) begin
                  $error("handle_out: expected %0d, got %0d", want.handle, rsp_tdata[9:2]);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (req_tvalid && req_tready)
            answers.push_back(apply_request(req_tdata));
      end
   end

endmodule

/* tb/testbench.sv */
// Top of the sorted alarm queue testbench: clock, reset, request and response
// drivers, verdict. Depends on saq_pkg, saq_checker and sorted_alarm_queue_top.
`timescale 1ns / 100ps
module testbench;
   import saq_pkg::*;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [111:0] req_tdata;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [15:0]  rsp_tdata;
   int           fail_count;
   int           pending;
   int           cycles;
   bit           hold_rsp;
   int           live_handles[$];
   int           top_handle;

   sorted_alarm_queue_top DUT (.*);

   saq_checker checker_i (.*);

   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   function automatic int short_or_long_gap();
      if ($urandom_range(0, 19) == 0)
         return $urandom_range(10, 40);
      if ($urandom_range(0, 2) == 0)
         return 0;
      return $urandom_range(0, 3);
   endfunction

   function automatic logic [15:0] pick_owner();
      case ($urandom_range(0, 9))
         0: return 16'hffff;
         1: return 16'h0000;
         default: return 16'($urandom_range(1, 4));
      endcase
   endfunction

   task automatic send_word(mode_type mode, logic [15:0] owner, logic [7:0] hnd,
                            logic [15:0] sig, logic [31:0] delay, logic [31:0] now);
      req_tdata = {6'd0, now, delay, sig, hnd, owner, mode};
      req_tvalid = 1;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      @(negedge clock);
      req_tvalid = 0;
      repeat (short_or_long_gap()) @(negedge clock);
   endtask

   task automatic random_request();
      logic [31:0] dly, now;
      int pick;
      dly = $urandom();
      now = $urandom();
      if ($urandom_range(0, 3) == 0)
         dly = $urandom_range(0, 3);
      if ($urandom_range(0, 3) == 0)
         now = 32'hffff_fff0 + $urandom_range(0, 15);
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
         send_word(mode_type'($urandom_range(1, 2)),
                   pick < 47 ? 16'($urandom_range(1, 65535)) : pick_owner(),
                   pick < 45 ? 8'd0 : 8'($urandom_range(1, 255)),
                   16'($urandom()), dly, now);
         live_handles.push_back(top_handle);
         top_handle++;
      end else if (pick < 80) begin
         send_word(MODE_DELETE, 16'($urandom()),
                   (live_handles.size() > 0 && pick < 75)
                      ? 8'(live_handles[$urandom_range(0, live_handles.size() - 1)])
                      : 8'($urandom_range(0, 255)),
                   16'($urandom()), dly, now);
      end else begin
         send_word(MODE_KILL, pick_owner(), 8'($urandom()), 16'($urandom()), dly, now);
      end
   endtask

   // response side stalls at random; long hold while hold_rsp is set
   initial begin
      int gap;
      rsp_tready = 0;
      @(negedge clock);
      forever begin
         if (hold_rsp) begin
            rsp_tready <= 0;
            repeat (60) @(negedge clock);
            hold_rsp = 0;
         end
         rsp_tready <= 1;
         repeat ($urandom_range(1, 8)) @(negedge clock);
         if ($urandom_range(0, 1)) begin
            gap = short_or_long_gap();
            if (gap > 0) begin
               rsp_tready <= 0;
               repeat (gap) @(negedge clock);
            end
         end
      end
   end

   initial begin
      cycles = 0;
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles > 1000000) begin
            $display("[sorted_alarm_queue_top] ERROR");
            $finish;
         end
      end
   end

   initial begin
      reset = 1;
      req_tvalid = 0;
      req_tdata = '0;
      hold_rsp = 0;
      top_handle = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      @(negedge clock);

      // directed: bad calls, sorting ties, wraparound, deletes and kills
      send_word(MODE_DELETE, 16'd1, 8'd0, 16'd0, 32'd0, 32'd0);
      send_word(MODE_DELETE, 16'd1, 8'hff, 16'd0, 32'd0, 32'd0);
      send_word(MODE_SET, 16'd0, 8'd0, 16'd1, 32'd5, 32'd0);
      send_word(MODE_SET, 16'd7, 8'hff, 16'd1, 32'd5, 32'd0);
      send_word(MODE_SET, 16'hffff, 8'd0, 16'hffff, 32'hffff_ffff, 32'hffff_ffff);
      send_word(MODE_CYCLE, 16'd2, 8'd0, 16'd0, 32'd0, 32'd0);
      send_word(MODE_SET, 16'd2, 8'd0, 16'd3, 32'd0, 32'd0);
      send_word(MODE_CYCLE, 16'd3, 8'd0, 16'd4, 32'd10, 32'd0);
      send_word(MODE_KILL, 16'd9, 8'd0, 16'd0, 32'd0, 32'd0);
      send_word(MODE_KILL, 16'd0, 8'd0, 16'd0, 32'd0, 32'd0);
      send_word(MODE_DELETE, 16'd0, 8'd1, 16'd0, 32'd0, 32'd0);
      send_word(MODE_DELETE, 16'd0, 8'd1, 16'd0, 32'd0, 32'd0);
      send_word(MODE_KILL, 16'd2, 8'd0, 16'd0, 32'd0, 32'd0);
      for (int i = 0; i < 17; i++)
         send_word(MODE_SET, 16'd5, 8'd0, 16'(i), 32'(i % 3), 32'd100);
      send_word(MODE_KILL, 16'd5, 8'd0, 16'd0, 32'd0, 32'd0);
      top_handle = 20;
      for (int i = 0; i < 20; i++)
         live_handles.push_back(i);

      while (pending != 0)
         @(negedge clock);
      hold_rsp = 1;
      for (int i = 0; i < 400; i++) begin
         random_request();
         if (i == 200) begin
            while (pending != 0)
               @(negedge clock);
         end
      end
      // drain handle space, then a few more with handles used up
      for (int i = 0; i < 420; i++)
         random_request();
      for (int i = 0; i < 20; i++)
         send_word(MODE_SET, 16'd8, 8'd0, 16'd0, 32'($urandom()), 32'd0);

      while (pending != 0)
         @(negedge clock);
      repeat (10) @(negedge clock);
      if (fail_count == 0)
         $display("[sorted_alarm_queue_top] OK");
      else
         $display("[sorted_alarm_queue_top] ERROR");
      $finish;
   end

endmodule

/* sim.f */
src/saq_pkg.sv
src/saq_cell.sv
src/saq_chain.sv
src/sorted_alarm_queue_top.sv
tb/saq_checker.sv
tb/testbench.sv
